// ===== src/kwm_pkg.sv =====
package kwm_pkg;

  localparam int MAX_STREAMS = 8;
  localparam int VALUE_BITS  = 32;
  localparam int STREAM_W    = 3;
  localparam int CFG_W       = 4;
  localparam int SLOT_W      = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
  localparam int COUNT_W     = $clog2(MAX_STREAMS + 1);
  localparam int LEAVES      = 2 ** SLOT_W;
  localparam int TREE_LEVELS = SLOT_W;
  localparam int SETTLE_W    = $clog2(TREE_LEVELS + 1);
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  typedef struct packed {
    logic                         valid;
    logic signed [VALUE_BITS-1:0] value;
    logic [STREAM_W-1:0]          stream;
    logic [SLOT_W-1:0]            slot;
  } node_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_push;
    logic merge_replace;
    logic merge_drop;
    logic capture;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic root_valid;
    logic stream_match;
    logic out_free;
  } stat_t;

  // smaller value wins, equal values go to the lower stream
  function automatic node_t pick_min(node_t a, node_t b);
    node_t r;
    r = b;
    if (a.valid && (!b.valid || a.value < b.value ||
                    (a.value == b.value && a.stream < b.stream))) begin
      r = a;
    end
    return r;
  endfunction

endpackage

// ===== src/kwm_if.sv =====
interface kwm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [kwm_pkg::STREAM_W-1:0]         stream_index;
  logic signed [kwm_pkg::VALUE_BITS-1:0] element_value;
  logic                                 stream_end;

  modport source (output valid, output stream_index, output element_value,
                  output stream_end, input ready);
  modport sink (input valid, input stream_index, input element_value,
                input stream_end, output ready);
endinterface

interface kwm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [kwm_pkg::VALUE_BITS-1:0] merged_value;
  logic [kwm_pkg::STREAM_W-1:0]         source_stream;
  logic                                 merge_done;

  modport source (output valid, output merged_value, output source_stream,
                  output merge_done, input ready);
  modport sink (input valid, input merged_value, input source_stream,
                input merge_done, output ready);
endinterface

// ===== src/k_way_sorted_merge_top.sv =====
// k-way sorted merge of up to eight ascending streams of signed 32-bit values
// in_i  : requests carry stream_index, element_value and stream_end
// out_o : results carry merged_value, source_stream and merge_done
// cfg   : cfg_we_i writes streams_in_use (reset 8) from cfg_data_i
// load phase: streams 0, 1, ... send their first element or an end marker in
// turn; out-of-turn requests are taken and dropped
// merge phase: each result names the stream whose next request is expected;
// requests from other streams are taken and dropped
// a request that updates a head passes through the three-level registered min
// tree before its result is captured; in_i.ready stays low meanwhile, so the
// next request is taken only after that result has been captured
// a done result (value 0, stream 0) ends the merge; later requests are
// consumed with no result until reset
// reset clears counts and returns to the load phase; head entries are
// written before use and need no clearing
// a stalled receiver holds the result register, the block waits before the
// next result but keeps taking the request that feeds it
module k_way_sorted_merge_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  kwm_in_if.sink                    in_i,
  kwm_out_if.source                 out_o,
  input  logic                      cfg_we_i,
  input  logic [kwm_pkg::CFG_W-1:0] cfg_data_i
);
  import kwm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  kwm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_stream_i(in_i.stream_index),
    .in_end_i   (in_i.stream_end),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  kwm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_stream_i (in_i.stream_index),
    .in_value_i  (in_i.element_value),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_value_o (out_o.merged_value),
    .out_stream_o(out_o.source_stream),
    .out_done_o  (out_o.merge_done)
  );

`ifndef SYNTH
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_push, cmd.merge_replace, cmd.merge_drop, cmd.capture}))
    else $error("more than one datapath command at once");

  a_capture_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |-> stat.out_free)
    else $error("result captured over a pending result");

  a_update_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.merge_replace || cmd.merge_drop) |->
      (in_i.valid && in_i.ready && stat.stream_match))
    else $error("head update without a matching request");

  a_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.merge_done) |->
      (out_o.merged_value == '0 && out_o.source_stream == '0))
    else $error("done result carries a value");
`endif

endmodule

// ===== src/kwm_datapath.sv =====
module kwm_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  kwm_pkg::cmd_t                         cmd_i,
  output kwm_pkg::stat_t                        stat_o,
  input  logic [kwm_pkg::STREAM_W-1:0]          in_stream_i,
  input  logic signed [kwm_pkg::VALUE_BITS-1:0] in_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [kwm_pkg::VALUE_BITS-1:0] out_value_o,
  output logic [kwm_pkg::STREAM_W-1:0]          out_stream_o,
  output logic                                  out_done_o
);
  import kwm_pkg::*;

  logic signed [VALUE_BITS-1:0] head_values_q [MAX_STREAMS];
  logic [STREAM_W-1:0]          head_streams_q [MAX_STREAMS];
  logic [COUNT_W-1:0]           live_count_q;
  logic [SLOT_W-1:0]            pend_slot_q;
  logic [STREAM_W-1:0]          pend_stream_q;
  logic [SLOT_W-1:0]            push_slot;
  logic [SLOT_W-1:0]            last_slot;
  logic [COUNT_W-1:0]           last_count;

  node_t leaf    [LEAVES];
  node_t node_q  [1:LEAVES-1];
  node_t all_nd  [1:2*LEAVES-1];
  node_t root;

  logic                         out_valid_q;
  logic signed [VALUE_BITS-1:0] out_value_q;
  logic [STREAM_W-1:0]          out_stream_q;
  logic                         out_done_q;
  logic                         out_free;

  assign push_slot  = live_count_q[SLOT_W-1:0];
  assign last_count = live_count_q - COUNT_W'(1);
  assign last_slot  = last_count[SLOT_W-1:0];

  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < MAX_STREAMS) begin : g_used
      assign leaf[i].valid  = COUNT_W'(i) < live_count_q;
      assign leaf[i].value  = head_values_q[i];
      assign leaf[i].stream = head_streams_q[i];
      assign leaf[i].slot   = SLOT_W'(i);
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  always_comb begin
    for (int j = 1; j < 2 * LEAVES; j++) begin
      if (j < LEAVES) begin
        all_nd[j] = node_q[j];
      end else begin
        all_nd[j] = leaf[j - LEAVES];
      end
    end
  end

  assign root = all_nd[1];

  // each tree level is registered; the root settles once every level has updated
  always_ff @(posedge clk_i) begin
    for (int j = 1; j < LEAVES; j++) begin
      node_q[j] <= pick_min(all_nd[2*j], all_nd[2*j+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_push) begin
      head_values_q[push_slot]  <= in_value_i;
      head_streams_q[push_slot] <= in_stream_i;
    end else if (cmd_i.merge_replace) begin
      head_values_q[pend_slot_q] <= in_value_i;
    end else if (cmd_i.merge_drop) begin
      head_values_q[pend_slot_q]  <= head_values_q[last_slot];
      head_streams_q[pend_slot_q] <= head_streams_q[last_slot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_count_q <= '0;
    end else if (cmd_i.load_push) begin
      live_count_q <= live_count_q + COUNT_W'(1);
    end else if (cmd_i.merge_drop) begin
      live_count_q <= last_count;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.capture) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      if (root.valid) begin
        out_value_q   <= root.value;
        out_stream_q  <= root.stream;
        out_done_q    <= 1'b0;
        pend_slot_q   <= root.slot;
        pend_stream_q <= root.stream;
      end else begin
        out_value_q  <= '0;
        out_stream_q <= '0;
        out_done_q   <= 1'b1;
      end
    end
  end

  assign stat_o.root_valid   = root.valid;
  assign stat_o.stream_match = in_stream_i == pend_stream_q;
  assign stat_o.out_free     = out_free;

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_stream_o = out_stream_q;
  assign out_done_o   = out_done_q;

endmodule

// ===== src/kwm_ctrl.sv =====
module kwm_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kwm_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [kwm_pkg::STREAM_W-1:0]  in_stream_i,
  input  logic                          in_end_i,
  input  kwm_pkg::stat_t                stat_i,
  output kwm_pkg::cmd_t                 cmd_o
);
  import kwm_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_MERGE,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [CFG_W-1:0]    cfg_q;
  logic [COUNT_W-1:0]  load_cnt_q;
  logic [SETTLE_W-1:0] settle_q;
  logic [COUNT_W-1:0]  eff_n;
  logic [COUNT_W-1:0]  load_next;
  logic                accept;
  logic                in_turn;
  logic                load_open;

  always_comb begin
    if (cfg_q == '0) begin
      eff_n = COUNT_W'(1);
    end else if (int'(cfg_q) > MAX_STREAMS) begin
      eff_n = COUNT_W'(MAX_STREAMS);
    end else begin
      eff_n = COUNT_W'(cfg_q);
    end
  end

  assign in_ready_o = state_q != ST_SETTLE;
  assign accept     = in_valid_i && in_ready_o;
  assign load_open  = load_cnt_q < eff_n;
  assign in_turn    = int'(in_stream_i) == int'(load_cnt_q);
  assign load_next  = load_cnt_q + COUNT_W'(1);

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_LOAD: begin
        cmd_o.load_push = accept && load_open && in_turn && !in_end_i;
      end
      ST_SETTLE: begin
        cmd_o.capture = settle_q == '0 && stat_i.out_free;
      end
      ST_MERGE: begin
        cmd_o.merge_replace = accept && stat_i.stream_match && !in_end_i;
        cmd_o.merge_drop    = accept && stat_i.stream_match && in_end_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      cfg_q      <= CFG_RESET;
      load_cnt_q <= '0;
      settle_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      case (state_q)
        ST_LOAD: begin
          if (accept) begin
            if (!load_open) begin
              // count lowered to or below what was loaded: drop this request
              state_q  <= ST_SETTLE;
              settle_q <= SETTLE_W'(TREE_LEVELS);
            end else if (in_turn) begin
              load_cnt_q <= load_next;
              if (load_next >= eff_n) begin
                state_q  <= ST_SETTLE;
                settle_q <= SETTLE_W'(TREE_LEVELS);
              end
            end
          end
        end
        ST_SETTLE: begin
          if (settle_q != '0) begin
            settle_q <= settle_q - SETTLE_W'(1);
          end else if (stat_i.out_free) begin
            state_q <= stat_i.root_valid ? ST_MERGE : ST_DONE;
          end
        end
        ST_MERGE: begin
          if (accept && stat_i.stream_match) begin
            state_q  <= ST_SETTLE;
            settle_q <= SETTLE_W'(TREE_LEVELS);
          end
        end
        ST_DONE: begin
          state_q <= ST_DONE;
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

endmodule
